[rtl/csvkh_pkg.sv]
package csvkh_pkg;

  localparam int unsigned MAX_COLUMNS_DEFAULT = 64;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned MASK_W = 64;
  localparam int unsigned PADDR_W = 4;

  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [31:0] KEY_SEED = 32'd3;
  localparam logic [7:0] COUNT_MAX = 8'd255;

  localparam logic REG_COLUMN_MASK = 1'b0;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       hash_byte;
    logic       close;
    logic       select;
    logic       last;
    logic [7:0] count;
  } op_t;

endpackage

[rtl/csvkh_if.sv]
interface csvkh_line_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       end_of_line;

  modport source (output valid, output line_byte, output end_of_line, input ready);
  modport sink (input valid, input line_byte, input end_of_line, output ready);
endinterface

interface csvkh_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] key_hash;
  logic [7:0]  tokens_seen;

  modport source (output valid, output key_hash, output tokens_seen, input ready);
  modport sink (input valid, input key_hash, input tokens_seen, output ready);
endinterface

[rtl/csvkh_front.sv]
module csvkh_front #(
  parameter int unsigned MAX_COLUMNS = csvkh_pkg::MAX_COLUMNS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [csvkh_pkg::MASK_W-1:0] column_mask,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  line_byte,
  input  logic                        end_of_line,
  output logic                        op_valid,
  input  logic                        op_ready,
  output csvkh_pkg::op_t              op
);

  logic       inside_token;
  logic       past_first_token;
  logic [7:0] token_number;
  logic       delim;
  logic       close;
  logic       select;
  logic [7:0] count_next;
  logic       accept;

  assign in_ready = op_ready;
  assign op_valid = in_valid;
  assign accept = in_valid && op_ready;

  assign delim = (line_byte == csvkh_pkg::CHAR_COMMA) ||
                 (past_first_token && line_byte == csvkh_pkg::CHAR_NEWLINE);
  assign close = delim ? inside_token : end_of_line;
  assign select = (32'(token_number) < MAX_COLUMNS) &&
                  (token_number < 8'(csvkh_pkg::MASK_W)) &&
                  column_mask[token_number[5:0]];
  assign count_next = (close && token_number != csvkh_pkg::COUNT_MAX) ?
                      token_number + 8'd1 : token_number;

  always_comb begin
    op.byte_val = line_byte;
    op.hash_byte = !delim;
    op.close = close;
    op.select = select;
    op.last = end_of_line;
    op.count = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_token <= 1'b0;
      past_first_token <= 1'b0;
      token_number <= '0;
    end else if (accept) begin
      if (end_of_line) begin
        inside_token <= 1'b0;
        past_first_token <= 1'b0;
        token_number <= '0;
      end else begin
        inside_token <= !delim;
        past_first_token <= past_first_token || close;
        token_number <= count_next;
      end
    end
  end

endmodule

[rtl/csvkh_queue.sv]
module csvkh_queue #(
  parameter int unsigned DEPTH = csvkh_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  csvkh_pkg::op_t push_op,
  output logic           pop_valid,
  input  logic           pop_ready,
  output csvkh_pkg::op_t pop_op
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  csvkh_pkg::op_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic push;
  logic pop;

  assign push_ready = fill != CNT_W'(DEPTH);
  assign pop_valid = fill != '0;
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;
  assign pop_op = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(DEPTH)) else $error("queue overfilled");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    fill == '0 |-> wr_ptr == rd_ptr) else $error("queue pointers disagree");

endmodule

[rtl/csvkh_back.sv]
module csvkh_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           op_valid,
  output logic           op_ready,
  input  csvkh_pkg::op_t op,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    key_hash,
  output logic [7:0]     tokens_seen
);

  logic [31:0] token_hash;
  logic [31:0] running_key;
  logic [31:0] byte_ext;
  logic [31:0] hash_next;
  logic [31:0] key_next;
  logic        out_free;
  logic        take;

  assign out_free = !out_valid || out_ready;
  assign op_ready = !op.last || out_free;
  assign take = op_valid && op_ready;

  assign byte_ext = {{24{op.byte_val[7]}}, op.byte_val};
  assign hash_next = op.hash_byte ?
                     (token_hash << 5) - token_hash + byte_ext : token_hash;
  assign key_next = (op.close && op.select) ?
                    (running_key << 4) + running_key + hash_next : running_key;

  always_ff @(posedge clk) begin
    if (rst) begin
      token_hash <= '0;
      running_key <= csvkh_pkg::KEY_SEED;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        if (op.last) begin
          token_hash <= '0;
          running_key <= csvkh_pkg::KEY_SEED;
          out_valid <= 1'b1;
        end else begin
          token_hash <= op.close ? '0 : hash_next;
          running_key <= key_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && op.last) begin
      key_hash <= key_next;
      tokens_seen <= op.count;
    end
  end

  a_line_clears: assert property (@(posedge clk) disable iff (rst)
    take && op.last |=> running_key == csvkh_pkg::KEY_SEED && token_hash == '0)
    else $error("line state not cleared");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(key_hash))
    else $error("pending result lost");

endmodule

[rtl/csv_column_key_hash_top.sv]
// CSV column key hasher: takes one byte of a text line per word, splits the line into
// comma-separated tokens (after the first token a newline also ends a token), hashes each
// token with h = 31*h + byte (sign-extended byte) and folds the tokens selected by
// column_mask into key = 17*key + h starting from 3; the word flagged end_of_line yields one
// result with the key and the token count (saturating at 255). Sustained rate is one byte per
// cycle unless the queue or a held result stalls, set by the token hash and key update in
// the back end; results are registered after the queue. column_mask sits at APB address 0
// (64-bit data), to be written by the user only while no line is in flight (unenforced).
module csv_column_key_hash_top #(
  parameter int unsigned MAX_COLUMNS = csvkh_pkg::MAX_COLUMNS_DEFAULT,
  parameter int unsigned QUEUE_DEPTH = csvkh_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [csvkh_pkg::PADDR_W-1:0] paddr,
  input  logic [csvkh_pkg::MASK_W-1:0]  pwdata,
  output logic [csvkh_pkg::MASK_W-1:0]  prdata,
  output logic                          pready,
  csvkh_line_if.sink                    line,
  csvkh_result_if.source                result
);

  logic [csvkh_pkg::MASK_W-1:0] column_mask;
  logic                         reg_hit;
  logic                         push_valid;
  logic                         push_ready;
  csvkh_pkg::op_t               push_op;
  logic                         pop_valid;
  logic                         pop_ready;
  csvkh_pkg::op_t               pop_op;

  assign pready = 1'b1;
  assign reg_hit = paddr[3] == csvkh_pkg::REG_COLUMN_MASK;
  assign prdata = reg_hit ? column_mask : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_mask <= '0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      column_mask <= pwdata;
    end
  end

  csvkh_front #(.MAX_COLUMNS(MAX_COLUMNS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .column_mask (column_mask),
    .in_valid    (line.valid),
    .in_ready    (line.ready),
    .line_byte   (line.line_byte),
    .end_of_line (line.end_of_line),
    .op_valid    (push_valid),
    .op_ready    (push_ready),
    .op          (push_op)
  );

  csvkh_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op)
  );

  csvkh_back u_back (
    .clk         (clk),
    .rst         (rst),
    .op_valid    (pop_valid),
    .op_ready    (pop_ready),
    .op          (pop_op),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .key_hash    (result.key_hash),
    .tokens_seen (result.tokens_seen)
  );

endmodule

[bench/csvkh_checker.sv]
module csvkh_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [csvkh_pkg::PADDR_W-1:0] paddr,
  input  logic [csvkh_pkg::MASK_W-1:0]  pwdata,
  csvkh_line_if                         line_mon,
  csvkh_result_if                       result_mon,
  output int                            failures,
  output int                            outstanding
);
  import csvkh_pkg::*;

  localparam int unsigned COLS = MAX_COLUMNS_DEFAULT;

  typedef struct packed {
    logic [31:0] key_hash;
    logic [7:0]  tokens_seen;
  } line_result_t;

  line_result_t      line_result_q[$];
  logic [MASK_W-1:0] column_sel;
  logic [31:0]       token_acc;
  logic [31:0]       line_key;
  logic [7:0]        token_idx;
  logic              in_token;
  logic              past_first;
  int                fail_count = 0;

  task automatic clear_line();
    token_acc  = '0;
    line_key   = KEY_SEED;
    token_idx  = '0;
    in_token   = 1'b0;
    past_first = 1'b0;
  endtask

  task automatic finish_token();
    if (token_idx < COLS && column_sel[token_idx[5:0]]) begin
      line_key = line_key * 32'd17 + token_acc;
    end
    if (token_idx < COUNT_MAX) begin
      token_idx = token_idx + 8'd1;
    end
    past_first = 1'b1;
    token_acc  = '0;
    in_token   = 1'b0;
  endtask

  task automatic absorb_word(input logic [7:0] b, input logic eol);
    logic         delim;
    line_result_t done;
    delim = (b == CHAR_COMMA) || (past_first && b == CHAR_NEWLINE);
    if (delim) begin
      if (in_token) begin
        finish_token();
      end
    end else begin
      token_acc = token_acc * 32'd31 + {{24{b[7]}}, b};
      in_token  = 1'b1;
    end
    if (eol) begin
      if (in_token) begin
        finish_token();
      end
      done.key_hash    = line_key;
      done.tokens_seen = token_idx;
      line_result_q.push_back(done);
      clear_line();
    end
  endtask

  always @(posedge clk) begin
    line_result_t want;
    if (rst) begin
      column_sel = '0;
      clear_line();
      line_result_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[PADDR_W-1:3] == REG_COLUMN_MASK) begin
        column_sel = pwdata;
      end
      if (line_mon.valid && line_mon.ready) begin
        absorb_word(line_mon.line_byte, line_mon.end_of_line);
      end
      if (result_mon.valid && result_mon.ready) begin
        if (line_result_q.size() == 0) begin
          $error("result word with no line pending: key_hash %h tokens_seen %0d",
                 result_mon.key_hash, result_mon.tokens_seen);
          fail_count++;
        end else begin
          want = line_result_q.pop_front();
          if (result_mon.key_hash !== want.key_hash) begin
            $error("key_hash mismatch: expected %h, got %h", want.key_hash,
                   result_mon.key_hash);
            fail_count++;
          end
          if (result_mon.tokens_seen !== want.tokens_seen) begin
            $error("tokens_seen mismatch: expected %0d, got %0d", want.tokens_seen,
                   result_mon.tokens_seen);
            fail_count++;
          end
        end
      end
    end
    failures    <= fail_count;
    outstanding <= line_result_q.size();
  end

endmodule

[bench/testbench.sv]
module testbench;
  import csvkh_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam logic [PADDR_W-1:0] ADDR_COLUMN_MASK = {REG_COLUMN_MASK, 3'b000};
  localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = {~REG_COLUMN_MASK, 3'b000};
  localparam logic [7:0] CHAR_A = 8'h61;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [MASK_W-1:0]  pwdata;
  logic [MASK_W-1:0]  prdata;
  logic               pready;

  int         src_idle_pct = 0;
  int         snk_idle_pct = 0;
  bit         hold_req = 0;
  int         bytes_sent = 0;
  int         failures;
  int         outstanding;
  logic [7:0] line_buf[$];

  csvkh_line_if   line_ch();
  csvkh_result_if result_ch();

  csv_column_key_hash_top u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .line    (line_ch),
    .result  (result_ch)
  );

  csvkh_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .line_mon    (line_ch),
    .result_mon  (result_ch),
    .failures    (failures),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((line_ch.valid && line_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (psel && penable)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("== FAIL ==");
    $finish;
  end

  task automatic put_word(input logic [7:0] b, input logic e);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      line_ch.valid <= 1'b0;
      @(posedge clk);
    end
    line_ch.valid       <= 1'b1;
    line_ch.line_byte   <= b;
    line_ch.end_of_line <= e;
    @(posedge clk);
    while (!line_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_buf();
    foreach (line_buf[i]) begin
      put_word(line_buf[i], i == line_buf.size() - 1);
    end
  endtask

  task automatic send_text(input string s);
    line_buf.delete();
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    send_buf();
  endtask

  // stop offering, then wait for every pending line result
  task automatic drain();
    line_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [MASK_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [7:0] token_char();
    logic [7:0] c;
    if ($urandom_range(3) != 0) begin
      c = CHAR_A + 8'($urandom_range(25));
    end else begin
      c = 8'($urandom_range(255));
      if (c == CHAR_COMMA || c == CHAR_NEWLINE) c = 8'h00;
    end
    return c;
  endfunction

  task automatic build_wellformed();
    int ntok;
    int len;
    line_buf.delete();
    ntok = $urandom_range(9);
    if ($urandom_range(4) == 0) line_buf.push_back(CHAR_COMMA);
    for (int t = 0; t < ntok; t++) begin
      len = $urandom_range(1, 5);
      repeat (len) line_buf.push_back(token_char());
      if (t < ntok - 1 || $urandom_range(1) == 1) begin
        repeat ($urandom_range(1, 2)) begin
          if (t == 0 || $urandom_range(1) == 0) line_buf.push_back(CHAR_COMMA);
          else line_buf.push_back(CHAR_NEWLINE);
        end
      end
    end
    if (line_buf.size() == 0) line_buf.push_back(CHAR_COMMA);
  endtask

  task automatic build_noise();
    int len;
    int r;
    line_buf.delete();
    len = $urandom_range(1, 12);
    repeat (len) begin
      r = $urandom_range(99);
      if (r < 30) line_buf.push_back(CHAR_COMMA);
      else if (r < 45) line_buf.push_back(CHAR_NEWLINE);
      else line_buf.push_back(8'($urandom_range(255)));
    end
  endtask

  task automatic build_many(input int n);
    line_buf.delete();
    repeat (n) begin
      line_buf.push_back(CHAR_A + 8'($urandom_range(25)));
      line_buf.push_back(CHAR_COMMA);
    end
  endtask

  task automatic run_lines(input int target);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < target) begin
      if ($urandom_range(99) < 20) build_noise();
      else build_wellformed();
      send_buf();
    end
  endtask

  initial begin
    rst                 <= 1'b1;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    line_ch.valid       <= 1'b0;
    line_ch.line_byte   <= '0;
    line_ch.end_of_line <= 1'b0;
    src_idle_pct = 11;
    snk_idle_pct = 72;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset mask selects nothing
    send_text("ab");
    drain();
    apb_write(ADDR_COLUMN_MASK, '1);
    send_text(",");
    send_text("\n");
    send_text("a,\nb");
    line_buf = {8'h00, 8'hFF, 8'h80, 8'h7F};
    send_buf();
    send_text(",,x,,y,");
    drain();
    apb_write(ADDR_UNMAPPED, {$urandom, $urandom});
    send_text("k,m");
    drain();
    apb_write(ADDR_COLUMN_MASK, '0);
    run_lines(40);
    drain();
    apb_write(ADDR_COLUMN_MASK, {1'b1, 62'b0, 1'b1});
    build_many(70);
    send_buf();
    build_many(258);
    send_buf();
    drain();

    apb_write(ADDR_COLUMN_MASK, {$urandom, $urandom});
    run_lines(100);
    drain();

    src_idle_pct = 72;
    snk_idle_pct = 11;
    apb_write(ADDR_COLUMN_MASK, '1);
    run_lines(100);
    drain();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    apb_write(ADDR_COLUMN_MASK, {$urandom, $urandom});
    hold_req = 1;
    run_lines(100);
    drain();

    repeat (6) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
